### hdl/dq_pkg.sv
// shared types and constants for the double-ended queue
package dq_pkg;

    localparam int DQ_CAPACITY = 16;
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 5;

    // operation codes of an input transaction
    typedef enum logic [1:0] {
        ACT_PUSH_BACK  = 2'd0,
        ACT_PUSH_FRONT = 2'd1,
        ACT_POP_BACK   = 2'd2,
        ACT_POP_FRONT  = 2'd3
    } t_action;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // per-cycle command broadcast along one chain of cells
    typedef struct packed {
        logic                      shift_up;   // move every entry one cell away from the head
        logic                      shift_down; // move every entry one cell toward the head
        logic                      write_tail; // write data into the cell at the fill level
        logic signed [VALUE_W-1:0] data;
    } t_cell_ctl;

endpackage

### hdl/dq_if.sv
// handshake channels for operation and result transactions
interface dq_cmd_if;
    import dq_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                action;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink (input valid, input action, input value, output ready);
endinterface

interface dq_rsp_if;
    import dq_pkg::*;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic signed [VALUE_W-1:0]     front_value;
    logic signed [VALUE_W-1:0]     back_value;
    logic [COUNT_OUT_W-1:0]        entry_count;
    logic                          is_empty;

    modport source (output valid, output status, output front_value, output back_value,
                    output entry_count, output is_empty, input ready);
    modport sink (input valid, input status, input front_value, input back_value,
                  input entry_count, input is_empty, output ready);
endinterface

### hdl/double_ended_queue.sv
// bounded double-ended queue built from two chains of shift cells
//
// Usage: each transaction on i_cmd carries an action (push back, push front,
// pop back, pop front) and a value used by pushes. Every accepted transaction
// yields one result transaction on o_rsp with a status, the front and back
// values after the operation (zero when empty), the entry count and an empty
// flag. A pop on an empty queue or a push on a full queue leaves the queue as
// it was and reports an error status.
// A result is valid in the cycle after acceptance; one transaction can be
// accepted every cycle unless o_rsp stalls. The queue is kept twice: one chain
// with the front in cell 0, one with the back in cell 0, so both ends are read
// at fixed places and each operation is at most one shift or write per chain.
// Reset empties the queue and drops any pending result; cell contents are not
// cleared since only occupied cells are ever read. When o_rsp is stalled the
// result register holds and i_cmd.ready drops until the result is taken.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int CAPACITY = DQ_CAPACITY
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dq_cmd_if.sink   i_cmd,
    dq_rsp_if.source o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic                      r_rsp_valid;
    t_status                   r_status;
    t_status                   n_status;
    logic signed [VALUE_W-1:0] r_front;
    logic signed [VALUE_W-1:0] r_back;
    logic [CW-1:0]             r_rsp_count;

    logic                      w_accept;
    logic                      w_full;
    logic                      w_empty;
    t_cell_ctl                 w_fctl;
    t_cell_ctl                 w_bctl;
    logic signed [VALUE_W-1:0] w_front_next;
    logic signed [VALUE_W-1:0] w_back_next;

    assign i_cmd.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);

    // decode the operation into chain commands and the new count
    always_comb begin
        w_fctl            = '0;
        w_bctl            = '0;
        w_fctl.data       = i_cmd.value;
        w_bctl.data       = i_cmd.value;
        n_count           = r_count;
        n_status          = ST_OK;
        unique case (t_action'(i_cmd.action))
            ACT_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_fctl.write_tail = w_accept;
                    w_bctl.shift_up   = w_accept;
                    n_count           = r_count + 1'b1;
                end
            end
            ACT_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_fctl.shift_up   = w_accept;
                    w_bctl.write_tail = w_accept;
                    n_count           = r_count + 1'b1;
                end
            end
            ACT_POP_BACK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_bctl.shift_down = w_accept;
                    n_count           = r_count - 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_fctl.shift_down = w_accept;
                    n_count           = r_count - 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // front chain: cell 0 holds the front element
    dq_chain #(.DEPTH(CAPACITY), .CW(CW)) u_front_chain (
        .i_clk       (i_clk),
        .i_ctl       (w_fctl),
        .i_count     (r_count),
        .o_head_next (w_front_next)
    );

    // back chain: cell 0 holds the back element
    dq_chain #(.DEPTH(CAPACITY), .CW(CW)) u_back_chain (
        .i_clk       (i_clk),
        .i_ctl       (w_bctl),
        .i_count     (r_count),
        .o_head_next (w_back_next)
    );

    // fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_accept) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_rsp_count <= n_count;
            r_front     <= (n_count == '0) ? '0 : w_front_next;
            r_back      <= (n_count == '0) ? '0 : w_back_next;
        end
    end

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.front_value = r_front;
    assign o_rsp.back_value  = r_back;
    assign o_rsp.entry_count = COUNT_OUT_W'(r_rsp_count);
    assign o_rsp.is_empty    = (r_rsp_count == '0);

    // fill level stays within capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count exceeds capacity");

    // a rejected transaction leaves the fill level unchanged
    a_error_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (n_status != ST_OK)) |=> (r_count == $past(r_count)))
        else $error("error transaction changed the count");

    // result count matches the fill level after the transaction
    a_rsp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_rsp_valid && (r_rsp_count == r_count)))
        else $error("result count does not match fill level");

    // a full error is only reported when the queue was full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (n_status == ST_FULL)) |-> w_full)
        else $error("full status without full queue");

endmodule

### hdl/dq_cell.sv
// one storage cell of a shift chain
module dq_cell
    import dq_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic [CW-1:0]             i_count,
    input  logic signed [VALUE_W-1:0] i_lower,
    input  logic signed [VALUE_W-1:0] i_upper,
    output logic signed [VALUE_W-1:0] o_val,
    output logic signed [VALUE_W-1:0] o_next
);

    logic signed [VALUE_W-1:0] r_val;
    logic signed [VALUE_W-1:0] n_val;

    // take from a neighbor on a shift, or the new entry when this cell is the fill level
    always_comb begin
        n_val = r_val;
        if (i_ctl.shift_up) begin
            n_val = i_lower;
        end else if (i_ctl.shift_down) begin
            n_val = i_upper;
        end else if (i_ctl.write_tail && (i_count == CW'(IDX))) begin
            n_val = i_ctl.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val  = r_val;
    assign o_next = n_val;

endmodule

### hdl/dq_chain.sv
// row of cells holding the queue as seen from one end
module dq_chain
    import dq_pkg::*;
#(
    parameter int DEPTH = DQ_CAPACITY,
    parameter int CW    = $clog2(DQ_CAPACITY + 1)
) (
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic [CW-1:0]             i_count,
    output logic signed [VALUE_W-1:0] o_head_next
);

    logic signed [VALUE_W-1:0] w_val [DEPTH];

    // cell 0 is the head; shift-up data enters there; each shift moves one cell
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            dq_cell #(.IDX(g), .CW(CW)) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (i_ctl),
                .i_count (i_count),
                .i_lower (i_ctl.data),
                .i_upper (w_val[g+1]),
                .o_val   (w_val[g]),
                .o_next  (o_head_next)
            );
        end else if (g == DEPTH - 1) begin : g_last
            dq_cell #(.IDX(g), .CW(CW)) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (i_ctl),
                .i_count (i_count),
                .i_lower (w_val[g-1]),
                .i_upper (w_val[g]),
                .o_val   (w_val[g]),
                .o_next  ()
            );
        end else begin : g_mid
            dq_cell #(.IDX(g), .CW(CW)) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (i_ctl),
                .i_count (i_count),
                .i_lower (w_val[g-1]),
                .i_upper (w_val[g+1]),
                .o_val   (w_val[g]),
                .o_next  ()
            );
        end
    end

endmodule

### dv/testbench.sv
// self-checking testbench for the double-ended queue with a shadow ring buffer
module testbench;
    import dq_pkg::*;

    // one expected result transaction
    typedef struct {
        t_status                   status;
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] back_value;
        logic [COUNT_OUT_W-1:0]    entry_count;
        logic                      is_empty;
    } t_expected;

    // shadow copy of the queue plus the results it still owes
    class deque_shadow;
        logic signed [VALUE_W-1:0] ring [DQ_CAPACITY];
        int                        head;
        int                        fill;
        int                        errors;
        t_expected                 due_results [$];

        function new();
            head   = 0;
            fill   = 0;
            errors = 0;
            foreach (ring[i]) ring[i] = '0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // apply one accepted operation and queue its result
        function void apply_op(t_action act, logic signed [VALUE_W-1:0] val);
            t_expected exp_rsp;
            exp_rsp.status = ST_OK;
            case (act) inside
                ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
                    if (fill >= DQ_CAPACITY) begin
                        exp_rsp.status = ST_FULL;
                    end else if (act == ACT_PUSH_BACK) begin
                        ring[(head + fill) % DQ_CAPACITY] = val;
                        fill++;
                    end else begin
                        head       = (head + DQ_CAPACITY - 1) % DQ_CAPACITY;
                        ring[head] = val;
                        fill++;
                    end
                end
                default: begin
                    if (fill == 0) begin
                        exp_rsp.status = ST_EMPTY;
                    end else if (act == ACT_POP_BACK) begin
                        fill--;
                    end else begin
                        head = (head + 1) % DQ_CAPACITY;
                        fill--;
                    end
                end
            endcase
            // both ends read zero when nothing is stored
            if (fill != 0) begin
                exp_rsp.front_value = ring[head];
                exp_rsp.back_value  = ring[(head + fill - 1) % DQ_CAPACITY];
            end else begin
                exp_rsp.front_value = '0;
                exp_rsp.back_value  = '0;
            end
            exp_rsp.entry_count = COUNT_OUT_W'(fill);
            exp_rsp.is_empty    = (fill == 0);
            due_results.insert(due_results.size(), exp_rsp);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100) $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        // compare one accepted result with the oldest expectation
        task check_result(logic [1:0] status, logic signed [VALUE_W-1:0] fv,
                          logic signed [VALUE_W-1:0] bv, logic [COUNT_OUT_W-1:0] cnt,
                          logic empty);
            t_expected exp_rsp;
            if (due_results.size() == 0) begin
                report("result transaction with no expectation waiting");
            end else begin
                exp_rsp = due_results[0];
                due_results.delete(0);
                if (status !== exp_rsp.status)
                    report($sformatf("status got %0d want %0d", status, exp_rsp.status));
                if (fv !== exp_rsp.front_value)
                    report($sformatf("front_value got %0d want %0d", fv,
                                     exp_rsp.front_value));
                if (bv !== exp_rsp.back_value)
                    report($sformatf("back_value got %0d want %0d", bv,
                                     exp_rsp.back_value));
                if (cnt !== exp_rsp.entry_count)
                    report($sformatf("entry_count got %0d want %0d", cnt,
                                     exp_rsp.entry_count));
                if (empty !== exp_rsp.is_empty)
                    report($sformatf("is_empty got %0b want %0b", empty, exp_rsp.is_empty));
            end
        endtask

        task flag_leftovers();
            if (due_results.size() != 0)
                report($sformatf("%0d expected results never arrived", due_results.size()));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        calm;
    logic        hold_req;
    deque_shadow shadow = new();

    dq_cmd_if cmd_ch ();
    dq_rsp_if rsp_ch ();

    double_ended_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // known values on every input from time zero
    initial begin
        i_rst_n       = 1'b0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.action = ACT_PUSH_BACK;
        cmd_ch.value  = '0;
        rsp_ch.ready  = 1'b0;
    end

    // run limit
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // observe both channels at every edge, inputs before results
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (cmd_ch.valid && cmd_ch.ready)
                    shadow.apply_op(t_action'(cmd_ch.action), cmd_ch.value);
                if (rsp_ch.valid && rsp_ch.ready)
                    shadow.check_result(rsp_ch.status, rsp_ch.front_value,
                                        rsp_ch.back_value, rsp_ch.entry_count,
                                        rsp_ch.is_empty);
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int  hold_left;
        bit  hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = 120;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (calm) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= 36);
            end
        end
    end

    // offer one operation, with random idle cycles ahead of it
    task send_op(t_action act, logic signed [VALUE_W-1:0] val);
        while (!calm && $urandom_range(99) < 36) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.action <= act;
        cmd_ch.value  <= val;
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    function logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // stimulus and end of run
    initial begin
        bit      filling;
        int      level;
        int      waited;
        t_action act;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pops on an empty queue
        send_op(ACT_POP_FRONT, 32'sd5);
        send_op(ACT_POP_BACK, -32'sd5);
        // value extremes through both ends
        send_op(ACT_PUSH_BACK, 32'sh7fff_ffff);
        send_op(ACT_PUSH_FRONT, 32'sh8000_0000);
        send_op(ACT_POP_BACK, '0);
        send_op(ACT_POP_FRONT, '0);
        // fill to capacity from alternating ends
        for (int k = 0; k < DQ_CAPACITY; k++) begin
            case (k % 4)
                0: send_op(ACT_PUSH_BACK, '0);
                1: send_op(ACT_PUSH_FRONT, -32'sd1);
                2: send_op(ACT_PUSH_BACK, 32'shaaaa_aaaa);
                default: send_op(ACT_PUSH_FRONT, 32'sh5555_5555);
            endcase
        end
        // pushes on a full queue
        send_op(ACT_PUSH_BACK, 32'sd1);
        send_op(ACT_PUSH_FRONT, 32'sd2);

        // random traffic that sweeps the fill level between empty and full
        filling = 1'b0;
        for (int n = 0; n < 1600; n++) begin
            if (n == 400) calm <= 1'b1;
            if (n == 700) calm <= 1'b0;
            if (n == 900) hold_req <= 1'b1;
            level = shadow.fill;
            if (level >= DQ_CAPACITY && $urandom_range(2) == 0) filling = 1'b0;
            else if (level == 0 && $urandom_range(2) == 0) filling = 1'b1;
            else if ($urandom_range(99) < 2) filling = !filling;
            if ($urandom_range(99) < (filling ? 75 : 25))
                act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
            else
                act = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
            send_op(act, pick_value());
        end
        cmd_ch.valid <= 1'b0;

        // drain remaining results, then let the design settle before the final check
        waited = 0;
        while (shadow.pending() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        shadow.flag_leftovers();
        if (shadow.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
